[hw/rtl/ius_pkg.sv]
package ius_pkg;

	localparam int DIM_W = 9;
	localparam int PIX_W = 8;

	localparam logic REG_IN_WIDTH  = 1'b0;
	localparam logic REG_IN_HEIGHT = 1'b1;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [1:0] TAP_NEAR_LO = 2'd0;
	localparam logic [1:0] TAP_NEAR_HI = 2'd1;
	localparam logic [1:0] TAP_FAR_LO  = 2'd2;
	localparam logic [1:0] TAP_FAR_HI  = 2'd3;

	typedef struct packed {
		logic             kind;
		logic [PIX_W-1:0] pixel_in;
		logic [DIM_W-1:0] out_x;
		logic [DIM_W-1:0] out_y;
	} item_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             bad_coord;
	} item_out_t;

	typedef struct packed {
		logic       capture;
		logic       load;
		logic       issue;
		logic [1:0] row_tap;
		logic [1:0] col_tap;
		logic       rows;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic bad;
		logic row_blend;
		logic col_blend;
	} sts_t;

endpackage

[hw/rtl/ius_ctrl.sv]
module ius_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  ius_pkg::sts_t sts,
	output ius_pkg::cmd_t cmd
);
	import ius_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ISSUE,
		ST_DRAIN,
		ST_ROWS,
		ST_FINISH
	} state_t;

	state_t     state_q;
	logic [1:0] row_q;
	logic [1:0] col_q;
	logic       drain_q;
	logic       out_valid_q;
	logic       out_free;
	logic [1:0] row_last;
	logic [1:0] col_last;

	assign out_free  = !out_valid_q || !out_stall;
	assign row_last  = sts.row_blend ? TAP_FAR_HI : TAP_NEAR_LO;
	assign col_last  = sts.col_blend ? TAP_FAR_HI : TAP_NEAR_LO;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.load     = (state_q == ST_DECODE) && (sts.kind == KIND_LOAD);
		cmd.issue    = (state_q == ST_ISSUE);
		cmd.row_tap  = row_q;
		cmd.col_tap  = col_q;
		cmd.rows     = (state_q == ST_ROWS);
		cmd.out_load = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= TAP_NEAR_LO;
			col_q       <= TAP_NEAR_LO;
			drain_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (sts.kind == KIND_LOAD) begin
						state_q <= ST_IDLE;
					end else if (sts.bad) begin
						state_q <= ST_FINISH;
					end else begin
						row_q   <= TAP_NEAR_LO;
						col_q   <= TAP_NEAR_LO;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (col_q == col_last) begin
						col_q <= TAP_NEAR_LO;
						if (row_q == row_last) begin
							drain_q <= 1'b0;
							state_q <= ST_DRAIN;
						end else begin
							row_q <= row_q + 2'd1;
						end
					end else begin
						col_q <= col_q + 2'd1;
					end
				end
				ST_DRAIN: begin
					if (drain_q) begin
						state_q <= ST_ROWS;
					end else begin
						drain_q <= 1'b1;
					end
				end
				ST_ROWS: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("pending result dropped");

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_DECODE)
		else $error("accepted request not decoded");

	a_copy_col_tap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE && !sts.col_blend |-> col_q == TAP_NEAR_LO)
		else $error("extra column tap issued");

	a_rows_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROWS |-> $past(state_q) == ST_DRAIN && $past(drain_q))
		else $error("row stage entered before reads landed");

endmodule

[hw/rtl/ius_dpath.sv]
module ius_dpath #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ius_pkg::item_in_t            in_item,
	input  logic                         cfg_valid,
	input  logic                         cfg_index,
	input  logic [ius_pkg::DIM_W-1:0]    cfg_data,
	input  ius_pkg::cmd_t                cmd,
	output ius_pkg::sts_t                sts,
	output ius_pkg::item_out_t           out_item
);
	import ius_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int LPW   = $clog2(DEPTH + 1);
	localparam logic [DIM_W-1:0] MAXW_CLAMP = (MAX_WIDTH > 511) ? 9'd511 : 9'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAXH_CLAMP = (MAX_HEIGHT > 511) ? 9'd511 : 9'(MAX_HEIGHT);

	function automatic logic [PIX_W-1:0] blend(
		input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b,
		input logic [PIX_W-1:0] c,
		input logic [PIX_W-1:0] d
	);
		logic signed [9:0]  ac;
		logic signed [9:0]  db;
		logic signed [9:0]  hac;
		logic signed [9:0]  hdb;
		logic [8:0]         sum;
		logic signed [12:0] n;
		logic [PIX_W-1:0]   result;
		ac  = $signed({2'b00, a}) - $signed({2'b00, c});
		db  = $signed({2'b00, d}) - $signed({2'b00, b});
		hac = (ac + $signed({9'd0, ac[9]})) >>> 1;
		hdb = (db + $signed({9'd0, db[9]})) >>> 1;
		sum = {1'b0, a} + {1'b0, b};
		n   = $signed({2'b00, sum, 2'b00}) + 13'(hac) - 13'(hdb);
		if (n[12]) begin
			result = '0;
		end else if (n[11]) begin
			result = 8'd255;
		end else begin
			result = n[10:3];
		end
		return result;
	endfunction

	function automatic logic [DIM_W-1:0] tap_index(
		input logic [DIM_W-2:0] base,
		input logic [1:0]       tap
	);
		logic [DIM_W-1:0] idx;
		unique case (tap)
			TAP_NEAR_LO: idx = {1'b0, base};
			TAP_NEAR_HI: idx = {1'b0, base} + 9'd1;
			TAP_FAR_LO:  idx = {1'b0, base} - 9'd1;
			TAP_FAR_HI:  idx = {1'b0, base} + 9'd2;
			default:     idx = {1'b0, base};
		endcase
		return idx;
	endfunction

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [LPW-1:0]   load_pos_q;
	item_in_t         item_q;

	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic [LPW-1:0]   total;
	logic             wr_en;
	logic [DIM_W-1:0] row_idx;
	logic [DIM_W-1:0] col_idx;
	logic [17:0]      lin_addr;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [AW-1:0]    addr_s1;
	logic [3:0]       tag_s1;
	logic             valid_s1;
	logic [PIX_W-1:0] rdata_s2;
	logic [3:0]       tag_s2;
	logic             valid_s2;

	logic [PIX_W-1:0] tap_q [4][4];
	logic [PIX_W-1:0] rv_q  [4];
	item_out_t        out_q;

	always_comb begin
		w_eff = width_q;
		if (width_q == '0) begin
			w_eff = 9'd1;
		end else if (width_q > MAXW_CLAMP) begin
			w_eff = MAXW_CLAMP;
		end
		h_eff = height_q;
		if (height_q == '0) begin
			h_eff = 9'd1;
		end else if (height_q > MAXH_CLAMP) begin
			h_eff = MAXH_CLAMP;
		end
	end

	assign total = LPW'(w_eff) * LPW'(h_eff);
	assign wr_en = cmd.load && (load_pos_q < total);

	assign sts.kind      = item_q.kind;
	assign sts.bad       = ({1'b0, item_q.out_x} >= {w_eff, 1'b0})
		|| ({1'b0, item_q.out_y} >= {h_eff, 1'b0});
	assign sts.col_blend = item_q.out_x[0] && (item_q.out_x >= 9'd3)
		&& (({1'b0, item_q.out_x} + 10'd4) < {w_eff, 1'b0});
	assign sts.row_blend = item_q.out_y[0] && (item_q.out_y >= 9'd3)
		&& (({1'b0, item_q.out_y} + 10'd4) < {h_eff, 1'b0});

	assign row_idx  = tap_index(item_q.out_y[DIM_W-1:1], cmd.row_tap);
	assign col_idx  = tap_index(item_q.out_x[DIM_W-1:1], cmd.col_tap);
	assign lin_addr = {9'd0, row_idx} * {9'd0, w_eff} + {9'd0, col_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 9'd256;
			height_q   <= 9'd256;
			load_pos_q <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_IN_WIDTH:  width_q  <= cfg_data;
					REG_IN_HEIGHT: height_q <= cfg_data;
					default:       width_q  <= width_q;
				endcase
			end
			if (wr_en) begin
				load_pos_q <= load_pos_q + LPW'(1);
			end
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[load_pos_q[AW-1:0]] <= item_q.pixel_in;
		end
		rdata_s2 <= mem[addr_s1];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
		end
		addr_s1 <= AW'(lin_addr);
		tag_s1  <= {cmd.row_tap, cmd.col_tap};
		tag_s2  <= tag_s1;
		if (valid_s2) begin
			tap_q[tag_s2[3:2]][tag_s2[1:0]] <= rdata_s2;
		end
		if (cmd.rows) begin
			for (int r = 0; r < 4; r++) begin
				rv_q[r] <= sts.col_blend
					? blend(tap_q[r][0], tap_q[r][1], tap_q[r][2], tap_q[r][3])
					: tap_q[r][0];
			end
		end
		if (cmd.out_load) begin
			out_q.bad_coord <= sts.bad;
			if (sts.bad) begin
				out_q.pixel_out <= '0;
			end else if (sts.row_blend) begin
				out_q.pixel_out <= blend(rv_q[0], rv_q[1], rv_q[2], rv_q[3]);
			end else begin
				out_q.pixel_out <= rv_q[0];
			end
		end
	end

	assign out_item = out_q;

endmodule

[hw/rtl/image_upscale_2x_interp.sv]
// Load request: the pixel is written to the store in the cycle after accept; no result.
// Read request: no store reads when out of range, one for a copied position, 4 when one axis
// interpolates, 16 when both axes interpolate, issued one at a time to the store.
// One request at a time; the next is accepted while a finished result waits at the output.
// Reset: control idles, load position 0, width and height 256; store contents undefined.
module image_upscale_2x_interp #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  ius_pkg::item_in_t         in_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output ius_pkg::item_out_t        out_item,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [ius_pkg::DIM_W-1:0] cfg_data
);
	import ius_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ius_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ius_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_item  (out_item)
	);

endmodule
